// ===== sv/otfg_pkg.sv =====
// Shared types, codes, constants and font lookup for the OLED text frame generator.
`default_nettype none

package otfg_pkg;

    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_DATA    = 2'd1,
        OP_CHAR    = 2'd2,
        OP_SETPOS  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_ADDR    = 2'd0,
        PH_CTRL    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    localparam logic [7:0] ADDR_RESET   = 8'h78;
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [3:0] NIBBLE       = 4'hF;

    localparam int GLYPH_COUNT = 31;
    localparam int GLYPH_COLS  = 5;

    typedef logic [4:0] glyph_idx_t;
    typedef logic [0:GLYPH_COLS-1][7:0] glyph_row_t;

    localparam glyph_row_t GLYPH_ROM [0:GLYPH_COUNT-1] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // blank
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, // 0
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00}, // 1
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, // 2
        '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31}, // 3
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, // 4
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39}, // 5
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, // 6
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03}, // 7
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, // 8
        '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}, // 9
        '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, // A
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, // C
        '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C}, // D
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, // E
        '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, // G
        '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}, // H
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, // I
        '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, // L
        '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, // M
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, // O
        '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, // P
        '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}, // R
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, // S
        '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}, // T
        '{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F}, // W
        '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62}, // %
        '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, // :
        '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, // .
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, // -
        '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02}  // /
    };

    typedef struct packed {
        op_t        op;
        logic [7:0] value;
        logic [2:0] page;
        logic [6:0] column;
        glyph_idx_t glyph;
    } item_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } out_word_t;

    // Fold to upper case, then map a character code to its font row.
    function automatic glyph_idx_t glyph_index(input logic [7:0] code);
        logic [7:0] up;
        glyph_idx_t idx;
        up = code;
        if (code inside {[8'h61:8'h7A]}) begin
            up = code - 8'h20;
        end
        if (up inside {[8'h30:8'h39]}) begin
            idx = glyph_idx_t'(up[3:0]) + 5'd1;
        end
        else begin
            case (up)
                8'h41:   idx = 5'd11; // A
                8'h43:   idx = 5'd12; // C
                8'h44:   idx = 5'd13; // D
                8'h45:   idx = 5'd14; // E
                8'h47:   idx = 5'd15; // G
                8'h48:   idx = 5'd16; // H
                8'h49:   idx = 5'd17; // I
                8'h4C:   idx = 5'd18; // L
                8'h4D:   idx = 5'd19; // M
                8'h4F:   idx = 5'd20; // O
                8'h50:   idx = 5'd21; // P
                8'h52:   idx = 5'd22; // R
                8'h53:   idx = 5'd23; // S
                8'h54:   idx = 5'd24; // T
                8'h57:   idx = 5'd25; // W
                8'h25:   idx = 5'd26; // %
                8'h3A:   idx = 5'd27; // :
                8'h2E:   idx = 5'd28; // .
                8'h2D:   idx = 5'd29; // -
                8'h2F:   idx = 5'd30; // /
                default: idx = 5'd0;
            endcase
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== sv/otfg_item_stage.sv =====
// Input register: holds one request and its decoded font row index until its last word leaves.
`default_nettype none

module otfg_item_stage
    import otfg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [7:0] value,
    input  wire logic [2:0] page,
    input  wire logic [6:0] column,
    input  wire logic       done,
    output logic            item_vld,
    output item_t           item
);

    logic  item_vld_reg;
    logic  item_vld_next;
    item_t item_reg;
    logic  accept;

    // Free the slot in the same cycle the last word moves out.
    assign in_ready = !item_vld_reg || done;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (accept)
        begin
            item_vld_next = 1'b1;
        end
        else if (done)
        begin
            item_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op     <= op_t'(op);
            item_reg.value  <= value;
            item_reg.page   <= page;
            item_reg.column <= column;
            item_reg.glyph  <= glyph_index(value);
        end
    end

    assign item_vld = item_vld_reg;
    assign item     = item_reg;

endmodule

`default_nettype wire

// ===== sv/otfg_byte_sel.sv =====
// Builds the bus word for the held request at a given transaction and phase.
`default_nettype none

module otfg_byte_sel
    import otfg_pkg::*;
(
    input  wire item_t       item,
    input  wire logic [7:0]  slave_addr,
    input  wire logic [2:0]  txn,
    input  wire phase_t      phase,
    output out_word_t        word
);

    logic [7:0] ctrl;
    logic [7:0] payload;
    logic [2:0] txn_last;

    always_comb
    begin
        ctrl     = CTRL_COMMAND;
        payload  = item.value;
        txn_last = 3'd0;
        case (item.op)
            OP_COMMAND:
            begin
                ctrl     = CTRL_COMMAND;
                payload  = item.value;
                txn_last = 3'd0;
            end
            OP_DATA:
            begin
                ctrl     = CTRL_DATA;
                payload  = item.value;
                txn_last = 3'd0;
            end
            OP_CHAR:
            begin
                ctrl     = CTRL_DATA;
                txn_last = 3'd5;
                // Spacer column after the five glyph columns.
                if (txn < 3'(GLYPH_COLS))
                begin
                    payload = GLYPH_ROM[item.glyph][txn];
                end
                else
                begin
                    payload = 8'h00;
                end
            end
            OP_SETPOS:
            begin
                ctrl     = CTRL_COMMAND;
                txn_last = 3'd2;
                case (txn)
                    3'd0:    payload = CMD_PAGE | {5'd0, item.page};
                    3'd1:    payload = {4'd0, item.column[3:0] & NIBBLE};
                    default: payload = CMD_COL_HIGH | {5'd0, item.column[6:4]};
                endcase
            end
            default:
            begin
                ctrl     = CTRL_COMMAND;
                payload  = item.value;
                txn_last = 3'd0;
            end
        endcase
    end

    always_comb
    begin
        word = '0;
        case (phase)
            PH_ADDR:
            begin
                word.bus_byte     = slave_addr;
                word.start_before = 1'b1;
            end
            PH_CTRL:
            begin
                word.bus_byte = ctrl;
            end
            PH_PAYLOAD:
            begin
                word.bus_byte   = payload;
                word.stop_after = 1'b1;
                word.last       = (txn == txn_last);
            end
            default:
            begin
                word = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/oled_text_frame_generator_unit.sv =====
// Top level of the OLED text frame generator: config register, byte sequencer, output register.
//
//   channel | signals                                     | word
//   --------+---------------------------------------------+------------------------------
//   in      | in_valid, in_ready, op, value, page, column | one display request
//   out     | out_valid, out_ready, bus_byte, start_before,| one I2C bus byte
//           | stop_after, last                            |
//   cfg     | cfg_valid, cfg_ready, cfg_data              | slave write address
//
// One bus byte per cycle unless out stalls; a command or data byte takes one transaction,
// set position three, a character six; the byte sequencer over the held request sets this.
// The next request is taken in the cycle its predecessor's last byte enters the output
// register, so requests follow each other with no gap.
// Reset clears the valid flags and the sequencer and loads the address 0x78.
// A stall on out holds the output register and the sequencer; cfg_ready is always high.
`default_nettype none

module oled_text_frame_generator_unit
    import otfg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [7:0] value,
    input  wire logic [2:0] page,
    input  wire logic [6:0] column,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      bus_byte,
    output logic            start_before,
    output logic            stop_after,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic       item_vld;
    item_t      item;
    out_word_t  word;
    logic       adv;
    logic       done;

    logic [7:0] addr_reg;
    logic [2:0] txn_reg;
    logic [2:0] txn_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       out_vld_reg;
    logic       out_vld_next;
    out_word_t  out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ADDR_RESET;
        end
        else if (cfg_valid)
        begin
            addr_reg <= cfg_data;
        end
    end

    otfg_item_stage u_item (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .value    (value),
        .page     (page),
        .column   (column),
        .done     (done),
        .item_vld (item_vld),
        .item     (item)
    );

    otfg_byte_sel u_sel (
        .item       (item),
        .slave_addr (addr_reg),
        .txn        (txn_reg),
        .phase      (phase_reg),
        .word       (word)
    );

    // Advance whenever a request is held and the output register is empty or being drained.
    assign adv  = item_vld && (!out_vld_reg || out_ready);
    assign done = adv && word.last;

    always_comb
    begin
        txn_next   = txn_reg;
        phase_next = phase_reg;
        if (adv)
        begin
            case (phase_reg)
                PH_ADDR:    phase_next = PH_CTRL;
                PH_CTRL:    phase_next = PH_PAYLOAD;
                PH_PAYLOAD:
                begin
                    phase_next = PH_ADDR;
                    txn_next   = word.last ? 3'd0 : txn_reg + 3'd1;
                end
                default:    phase_next = PH_ADDR;
            endcase
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txn_reg     <= 3'd0;
            phase_reg   <= PH_ADDR;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            txn_reg     <= txn_next;
            phase_reg   <= phase_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= word;
        end
    end

    assign out_valid    = out_vld_reg;
    assign bus_byte     = out_reg.bus_byte;
    assign start_before = out_reg.start_before;
    assign stop_after   = out_reg.stop_after;
    assign last         = out_reg.last;

endmodule

`default_nettype wire

// ===== sv/otfg_checker.sv =====
// Port-level checker for the OLED text frame generator, bound to the top level.
`default_nettype none

module otfg_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] bus_byte,
    input wire logic       start_before,
    input wire logic       stop_after,
    input wire logic       last
);

    // Address byte opens, payload byte closes: never both on one word.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(start_before && stop_after))
        else $error("start and stop flagged on the same word");

    a_last_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> stop_after)
        else $error("last flagged on a word without stop");

    // Within a transaction the control byte follows the address at once.
    a_addr_then_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && start_before |=>
            out_valid && !start_before && !stop_after)
        else $error("address byte not followed by control byte");

    a_ctrl_then_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !start_before && !stop_after |=>
            out_valid && stop_after)
        else $error("control byte not followed by payload byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bus_byte))
        else $error("stalled output word changed");

endmodule

bind oled_text_frame_generator_unit otfg_checker u_otfg_checker (.*);

`default_nettype wire
